// ----- sv/khsr_pkg.sv -----
// Package for the key hash slot router: transaction types, sizes, opcodes
// and the CRC-16 byte update. It depends on nothing else.
package khsr_pkg;

   localparam int SLOT_COUNT = 16384;
   localparam int NODE_LIMIT = 64;
   localparam int SLOT_WIDTH = $clog2(SLOT_COUNT);
   localparam int NODE_WIDTH = 6;
   localparam int ENTRY_WIDTH = NODE_WIDTH + 1;
   localparam int CRC_WIDTH = 16;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_WIDTH-1:0] BYTE_MASK = 16'h00FF;

   localparam logic OP_KEY_BYTE = 1'b0;
   localparam logic OP_MAP_WRITE = 1'b1;

   typedef struct packed {
      logic opcode;
      logic [7:0] key_byte;
      logic last_byte;
      logic [13:0] slot_number;
      logic [5:0] node_number;
   } req_type;

   typedef struct packed {
      logic [13:0] slot;
      logic [5:0] node_id;
      logic node_known;
   } rsp_type;

   // CRC-16 with polynomial 0x1021, MSB first, eight shift steps per byte.
   function automatic logic [CRC_WIDTH-1:0] crc_update(input logic [CRC_WIDTH-1:0] crc,
                                                       input logic [7:0] data);
      logic [CRC_WIDTH-1:0] c;
      c = crc ^ ((BYTE_MASK & {8'h00, data}) << 8);
      for (int i = 0; i < 8; i++) begin
         if (c[CRC_WIDTH-1]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- sv/key_hash_slot_router_unit.sv -----
// Top level of the key hash slot router: CRC-16 of streamed key bytes and a
// slot map memory lookup. It depends on khsr_pkg.
//
// The unit takes one transaction per cycle while req_stall is low: key bytes
// update a running CRC-16 register, and a map write goes straight to the slot
// map memory. For the last byte of a key the slot (the CRC modulo SLOT_COUNT, a
// power of two, so its low bits) addresses the slot map memory; the result
// reaches rsp through the synchronous memory read register and then the output
// register. Outside the clearing pass, req_stall rises only while a looked-up
// result cannot move on because the output register is full and stalled. After
// reset the slot map is cleared one entry per cycle, with req_stall held high
// throughout.
module key_hash_slot_router_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  khsr_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output khsr_pkg::rsp_type rsp_data
);

   logic [khsr_pkg::ENTRY_WIDTH-1:0] slot_map_mem [khsr_pkg::SLOT_COUNT];
   logic [khsr_pkg::ENTRY_WIDTH-1:0] rd_entry_ff;

   logic clear_ff, clear_in;
   logic [khsr_pkg::SLOT_WIDTH-1:0] clear_addr_ff, clear_addr_in;
   logic [khsr_pkg::CRC_WIDTH-1:0] crc_ff, crc_in;
   logic pend_ff, pend_in;
   logic [khsr_pkg::SLOT_WIDTH-1:0] pend_slot_ff, pend_slot_in;
   logic rsp_valid_ff, rsp_valid_in;
   khsr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic key_accept;
   logic key_last;
   logic map_accept;
   logic map_in_range;
   logic can_move;
   logic [khsr_pkg::CRC_WIDTH-1:0] crc_next;
   logic [khsr_pkg::SLOT_WIDTH-1:0] lookup_slot;
   logic wr_en;
   logic [khsr_pkg::SLOT_WIDTH-1:0] wr_addr;
   logic [khsr_pkg::ENTRY_WIDTH-1:0] wr_entry;

   assign can_move = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clear_ff || (pend_ff && !can_move);
   assign req_accept = req_valid && !req_stall;
   assign key_accept = req_accept && (req_data.opcode == khsr_pkg::OP_KEY_BYTE);
   assign key_last = key_accept && req_data.last_byte;
   assign map_in_range = (32'(req_data.slot_number) < khsr_pkg::SLOT_COUNT) &&
                         (32'(req_data.node_number) < khsr_pkg::NODE_LIMIT);
   assign map_accept = req_accept && (req_data.opcode == khsr_pkg::OP_MAP_WRITE) &&
                       map_in_range;
   assign crc_next = khsr_pkg::crc_update(crc_ff, req_data.key_byte);
   assign lookup_slot = crc_next[khsr_pkg::SLOT_WIDTH-1:0];

   always_comb begin
      wr_en = clear_ff || map_accept;
      if (clear_ff) begin
         wr_addr = clear_addr_ff;
         wr_entry = '0;
      end else begin
         wr_addr = req_data.slot_number[khsr_pkg::SLOT_WIDTH-1:0];
         wr_entry = {1'b1, req_data.node_number};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_map_mem[wr_addr] <= wr_entry;
      end
      if (key_last) begin
         rd_entry_ff <= slot_map_mem[lookup_slot];
      end
   end

   always_comb begin
      clear_in = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + khsr_pkg::SLOT_WIDTH'(1);
         if (32'(clear_addr_ff) == khsr_pkg::SLOT_COUNT - 1) begin
            clear_in = 1'b0;
         end
      end

      crc_in = crc_ff;
      if (key_accept) begin
         crc_in = key_last ? '0 : crc_next;
      end

      pend_in = pend_ff;
      pend_slot_in = pend_slot_ff;
      if (key_last) begin
         pend_in = 1'b1;
         pend_slot_in = lookup_slot;
      end else if (can_move) begin
         pend_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (can_move) begin
         rsp_valid_in = pend_ff;
         if (pend_ff) begin
            rsp_data_in.slot = pend_slot_ff;
            rsp_data_in.node_known = rd_entry_ff[khsr_pkg::NODE_WIDTH];
            rsp_data_in.node_id = rd_entry_ff[khsr_pkg::NODE_WIDTH]
                                  ? rd_entry_ff[khsr_pkg::NODE_WIDTH-1:0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clear_addr_ff <= '0;
         crc_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff <= clear_in;
         clear_addr_ff <= clear_addr_in;
         crc_ff <= crc_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_slot_ff <= pend_slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_last_clears_crc: assert property (@(posedge clock) disable iff (reset)
      key_last |=> (crc_ff == '0))
      else $error("CRC was not cleared after the last byte of a key.");

   a_write_keeps_crc: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.opcode == khsr_pkg::OP_MAP_WRITE) |=> $stable(crc_ff))
      else $error("A map write changed the running CRC.");

   a_last_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      key_last |=> pend_ff)
      else $error("The last byte of a key did not start a slot map lookup.");

   a_clear_is_quiet: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (req_stall && !pend_ff && !rsp_valid_ff))
      else $error("Activity during the slot map clearing pass.");

endmodule

// ----- tb/key_hash_slot_router_unit_tb.sv -----
// Self-checking testbench for key_hash_slot_router_unit: streams keys and slot map
// writes, predicts each lookup with a CRC-16 model and a slot map copy, and checks
// every result in order. It depends on khsr_pkg and the unit itself.
module key_hash_slot_router_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS_TOTAL = 700;
   localparam int QUIET_TAIL_START = 600;
   localparam int PRESSURE_START = 250;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3 * khsr_pkg::SLOT_COUNT;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS = 10;

   typedef bit [7:0] key_bytes_type[$];

   class slot_lookup_scoreboard;
      bit [khsr_pkg::CRC_WIDTH-1:0] crc_state;
      bit [khsr_pkg::ENTRY_WIDTH-1:0] slot_entry [khsr_pkg::SLOT_COUNT];
      khsr_pkg::rsp_type lookups_due[$];
      int failures;
      int keys_finished;
      int writes_seen;
      int known_hits;

      function bit [khsr_pkg::CRC_WIDTH-1:0] advance_crc(bit [khsr_pkg::CRC_WIDTH-1:0] crc,
                                                         bit [7:0] data);
         bit [khsr_pkg::CRC_WIDTH-1:0] c;
         c = crc ^ {data, 8'h00};
         for (int i = 0; i < 8; i++) begin
            c = c[khsr_pkg::CRC_WIDTH-1] ? ((c << 1) ^ khsr_pkg::CRC_POLY) : (c << 1);
         end
         return c;
      endfunction

      function bit [khsr_pkg::SLOT_WIDTH-1:0] slot_of(key_bytes_type bytes);
         bit [khsr_pkg::CRC_WIDTH-1:0] c;
         c = '0;
         foreach (bytes[i]) begin
            c = advance_crc(c, bytes[i]);
         end
         return khsr_pkg::SLOT_WIDTH'(c % khsr_pkg::SLOT_COUNT);
      endfunction

      function void note_request(khsr_pkg::req_type item);
         khsr_pkg::rsp_type want;
         if (item.opcode == khsr_pkg::OP_MAP_WRITE) begin
            writes_seen++;
            if (item.slot_number < khsr_pkg::SLOT_COUNT &&
                item.node_number < khsr_pkg::NODE_LIMIT) begin
               slot_entry[item.slot_number] = {1'b1, item.node_number};
            end
            return;
         end
         crc_state = advance_crc(crc_state, item.key_byte);
         if (!item.last_byte) begin
            return;
         end
         want.slot = khsr_pkg::SLOT_WIDTH'(crc_state % khsr_pkg::SLOT_COUNT);
         want.node_known = slot_entry[want.slot][khsr_pkg::NODE_WIDTH];
         want.node_id = want.node_known ? slot_entry[want.slot][khsr_pkg::NODE_WIDTH-1:0]
                                        : '0;
         lookups_due.push_back(want);
         keys_finished++;
         crc_state = '0;
      endfunction

      function void report(string what, khsr_pkg::rsp_type want, khsr_pkg::rsp_type got);
         failures++;
         if (failures <= MAX_REPORTS) begin
            $display("mismatch (%s): expected slot %0d node %0d known %0d,", what,
                     want.slot, want.node_id, want.node_known,
                     " got slot %0d node %0d known %0d",
                     got.slot, got.node_id, got.node_known);
         end
      endfunction

      function void check_result(khsr_pkg::rsp_type got);
         khsr_pkg::rsp_type want;
         if (lookups_due.size() == 0) begin
            report("no lookup pending", '0, got);
            return;
         end
         want = lookups_due.pop_front();
         if (got.slot !== want.slot) begin
            report("slot", want, got);
         end else if (got.node_id !== want.node_id) begin
            report("node_id", want, got);
         end else if (got.node_known !== want.node_known) begin
            report("node_known", want, got);
         end
         if (want.node_known) begin
            known_hits++;
         end
      endfunction

      function void close_out();
         while (lookups_due.size() != 0) begin
            report("result never arrived", lookups_due.pop_front(), '0);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   khsr_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   khsr_pkg::rsp_type rsp_data;

   slot_lookup_scoreboard lookup_board;
   int items_sent;
   int idle_odds;
   int idle_cycles;
   bit hold_off_request;
   bit pressure_done;

   key_hash_slot_router_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         lookup_board.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer_request(input khsr_pkg::req_type item);
      if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      lookup_board.note_request(item);
      items_sent++;
   endtask

   task automatic send_map_write(input bit [khsr_pkg::SLOT_WIDTH-1:0] slot,
                                 input bit [khsr_pkg::NODE_WIDTH-1:0] node);
      khsr_pkg::req_type item;
      item.opcode = khsr_pkg::OP_MAP_WRITE;
      item.key_byte = 8'($urandom);
      item.last_byte = 1'($urandom);
      item.slot_number = slot;
      item.node_number = node;
      offer_request(item);
   endtask

   task automatic send_key(input key_bytes_type bytes, input bit write_inside,
                           input bit own_slot);
      khsr_pkg::req_type item;
      int split;
      split = $urandom_range(0, bytes.size() - 1);
      foreach (bytes[i]) begin
         if (write_inside && i == split) begin
            send_map_write(own_slot ? lookup_board.slot_of(bytes)
                                    : khsr_pkg::SLOT_WIDTH'($urandom),
                           khsr_pkg::NODE_WIDTH'($urandom));
         end
         item.opcode = khsr_pkg::OP_KEY_BYTE;
         item.key_byte = bytes[i];
         item.last_byte = (i == bytes.size() - 1);
         item.slot_number = khsr_pkg::SLOT_WIDTH'($urandom);
         item.node_number = khsr_pkg::NODE_WIDTH'($urandom);
         offer_request(item);
      end
   endtask

   task automatic send_random_key(input int max_len);
      key_bytes_type bytes;
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, max_len) : $urandom_range(1, 4);
      repeat (len) bytes.push_back(8'($urandom));
      if ($urandom_range(0, 2) == 0) begin
         send_map_write(lookup_board.slot_of(bytes), khsr_pkg::NODE_WIDTH'($urandom));
      end
      send_key(bytes, len > 1 && $urandom_range(0, 5) == 0, 1'($urandom));
   endtask

   initial begin
      key_bytes_type check_string;
      lookup_board = new;
      idle_odds = 20;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_key('{8'h00}, 1'b0, 1'b0);
      send_map_write('0, '1);
      send_key('{8'h00}, 1'b0, 1'b0);
      check_string = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
      send_key(check_string, 1'b0, 1'b0);
      send_key(check_string, 1'b1, 1'b1);
      send_map_write('1, '0);
      send_map_write(lookup_board.slot_of('{8'hFF}), '0);
      send_key('{8'hFF}, 1'b0, 1'b0);
      send_map_write('0, 6'd1);
      send_key('{8'h00}, 1'b0, 1'b0);

      while (items_sent < RANDOM_ITEMS_TOTAL) begin
         if (items_sent >= QUIET_TAIL_START) begin
            idle_odds = 0;
         end else begin
            idle_odds = ((items_sent / 100) % 2 == 0) ? 25 : 0;
         end
         if (!pressure_done && items_sent >= PRESSURE_START) begin
            pressure_done = 1'b1;
            hold_off_request = 1'b1;
            repeat (40) send_key('{8'($urandom)}, 1'b0, 1'b0);
         end else if ($urandom_range(0, 99) < 12) begin
            send_map_write(khsr_pkg::SLOT_WIDTH'($urandom), khsr_pkg::NODE_WIDTH'($urandom));
         end else begin
            send_random_key(24);
         end
      end
      req_valid <= 1'b0;

      while (lookup_board.lookups_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      lookup_board.close_out();
      $display("summary: %0d transactions accepted, %0d keys hashed, %0d slot map writes",
               items_sent, lookup_board.keys_finished, lookup_board.writes_seen);
      $display("summary: %0d lookups hit an assigned node, one %0d-cycle receiver hold-off",
               lookup_board.known_hits, HOLD_OFF_CYCLES);
      if (lookup_board.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
